// ===== design/uart_rb_pkg.sv =====
// ----------------------------------------------------------------------------
// uart_rb_pkg
// Shared types and constants for the UART transmit/receive ring buffers.
// ----------------------------------------------------------------------------
package uart_rb_pkg;

  localparam int MAX_SLOTS    = 256;
  localparam int SIZE_RESET   = 128;
  localparam int CFG_W        = 9;
  localparam int CFG_IDX_W    = 1;
  localparam int BYTE_W       = 8;
  localparam int OPCODE_W     = 3;
  localparam int STATUS_W     = 3;
  localparam int COUNT_W      = 8;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 40;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TX_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RX_SIZE = 1'd1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_HOST_WRITE = 3'd0,
    OP_HOST_READ  = 3'd1,
    OP_LINE_RX    = 3'd2,
    OP_TX_READY   = 3'd3,
    OP_TX_FLUSH   = 3'd4,
    OP_RX_FLUSH   = 3'd5
  } opcode_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } ring_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ring_stat_t;

endpackage

// ===== design/uart_rb_ring.sv =====
// ----------------------------------------------------------------------------
// uart_rb_ring
// One byte ring with a configurable slot count, one slot kept empty.
// ----------------------------------------------------------------------------
module uart_rb_ring #(
  parameter int MAX_SLOTS = uart_rb_pkg::MAX_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [uart_rb_pkg::CFG_W-1:0]  cfg_data,
  input  uart_rb_pkg::ring_ctl_t         ctl,
  input  logic [uart_rb_pkg::BYTE_W-1:0] wdata,
  output uart_rb_pkg::ring_stat_t        stat,
  output logic [uart_rb_pkg::BYTE_W-1:0] head,
  output logic [uart_rb_pkg::COUNT_W-1:0] count_next
);

  localparam int PTR_W  = (MAX_SLOTS > 2) ? $clog2(MAX_SLOTS) : 1;
  localparam int SIZE_W = $clog2(MAX_SLOTS + 1);

  logic [SIZE_W-1:0] size;
  logic [PTR_W-1:0]  rptr;
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr_next;
  logic [PTR_W-1:0]  wptr_next;
  logic [PTR_W-1:0]  wptr_inc;
  logic [PTR_W-1:0]  rptr_inc;
  logic              push_do;
  logic              pop_do;
  logic [SIZE_W:0]   cnt;

  logic [uart_rb_pkg::BYTE_W-1:0] mem [MAX_SLOTS];
  logic [uart_rb_pkg::BYTE_W-1:0] head_q;

  function automatic logic [SIZE_W-1:0] clamp(input logic [uart_rb_pkg::CFG_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (int'(v) < 2) r = SIZE_W'(2);
    else if (int'(v) > MAX_SLOTS) r = SIZE_W'(MAX_SLOTS);
    else r = SIZE_W'(v);
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p,
                                            input logic [SIZE_W-1:0] s);
    logic [SIZE_W:0] n;
    n = (SIZE_W+1)'(p) + (SIZE_W+1)'(1);
    return (n >= (SIZE_W+1)'(s)) ? '0 : n[PTR_W-1:0];
  endfunction

  assign wptr_inc   = bump(wptr, size);
  assign rptr_inc   = bump(rptr, size);
  assign stat.full  = (wptr_inc == rptr);
  assign stat.empty = (wptr == rptr);
  assign push_do    = ctl.push && !stat.full;
  assign pop_do     = ctl.pop && !stat.empty;

  always_comb begin
    rptr_next = rptr;
    wptr_next = wptr;
    if (cfg_we || ctl.flush) begin
      rptr_next = '0;
      wptr_next = '0;
    end else begin
      if (push_do) wptr_next = wptr_inc;
      if (pop_do)  rptr_next = rptr_inc;
    end
  end

  // occupancy after this cycle's update
  always_comb begin
    if (wptr_next >= rptr_next) begin
      cnt = (SIZE_W+1)'(wptr_next) - (SIZE_W+1)'(rptr_next);
    end else begin
      cnt = (SIZE_W+1)'(wptr_next) + (SIZE_W+1)'(size) - (SIZE_W+1)'(rptr_next);
    end
  end
  assign count_next = uart_rb_pkg::COUNT_W'(cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      size <= clamp(uart_rb_pkg::CFG_W'(uart_rb_pkg::SIZE_RESET));
      rptr <= '0;
      wptr <= '0;
    end else begin
      if (cfg_we) size <= clamp(cfg_data);
      rptr <= rptr_next;
      wptr <= wptr_next;
    end
  end

  // storage; registered read of the slot at the next read pointer
  always_ff @(posedge clk) begin
    if (push_do) mem[wptr] <= wdata;
    if (push_do && (wptr == rptr_next)) head_q <= wdata;
    else head_q <= mem[rptr_next];
  end

  assign head = head_q;

endmodule

// ===== design/uart_rb_top.sv =====
// ----------------------------------------------------------------------------
// uart_tx_rx_ring_buffers_top
// Transmit and receive byte rings for a UART, driven by an event stream.
// ----------------------------------------------------------------------------
// Use:
//   Each request on the s_axis channel is one event: host write, host read,
//   line byte received, transmitter ready, tx flush or rx flush. Each event
//   gives exactly one result request on m_axis with the read byte, the byte
//   to send (if any), the interrupt enable, flags and both ring counts.
//   Ring sizes are written on the cfg port (index 0 tx, 1 rx) while idle;
//   a size write also empties that ring.
// Timing:
//   An event is registered on acceptance, processed once the result
//   register is free, and its result registered there to drive m_axis_tvalid.
//   One event per cycle is sustained while m_axis_tready is high; the limit
//   is the single write and single registered read port of each ring memory.
// Reset:
//   Synchronous rst empties both rings, clears the flags and sets both sizes
//   to 128 slots. Ring storage is not cleared; an empty ring is never read.
// Stall:
//   When m_axis_tready is low the result is held; one more event waits in
//   the input register, after which s_axis_tready drops.
// ----------------------------------------------------------------------------
module uart_tx_rx_ring_buffers_top #(
  parameter int MAX_SLOTS = uart_rb_pkg::MAX_SLOTS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // tdata: opcode[2:0], data_byte[10:3], line_status[13:11], zero pad
  input  logic [uart_rb_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: read_byte[7:0], send_valid[8], send_byte[16:9],
  //   ready_irq_enable[17], overflow[18], line_error[21:19],
  //   rx_count[29:22], tx_count[37:30], zero pad
  output logic [uart_rb_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  input  logic                                  cfg_we,
  input  logic [uart_rb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [uart_rb_pkg::CFG_W-1:0]         cfg_data
);

  // input register
  logic                                in_valid;
  logic [uart_rb_pkg::OPCODE_W-1:0]    in_opcode;
  logic [uart_rb_pkg::BYTE_W-1:0]      in_data;
  logic [uart_rb_pkg::STATUS_W-1:0]    in_status;
  logic                                adv;

  // status
  logic                                irq_en;
  logic                                irq_en_next;
  logic                                ovf;
  logic                                ovf_next;
  logic [uart_rb_pkg::STATUS_W-1:0]    err;
  logic [uart_rb_pkg::STATUS_W-1:0]    err_next;

  // ring interfaces
  uart_rb_pkg::ring_ctl_t              tx_ctl;
  uart_rb_pkg::ring_ctl_t              rx_ctl;
  uart_rb_pkg::ring_stat_t             tx_stat;
  uart_rb_pkg::ring_stat_t             rx_stat;
  logic [uart_rb_pkg::BYTE_W-1:0]      tx_head;
  logic [uart_rb_pkg::BYTE_W-1:0]      rx_head;
  logic [uart_rb_pkg::COUNT_W-1:0]     tx_cnt;
  logic [uart_rb_pkg::COUNT_W-1:0]     rx_cnt;

  // per-event results
  logic [uart_rb_pkg::BYTE_W-1:0]      rd_byte;
  logic                                snd_valid;
  logic [uart_rb_pkg::BYTE_W-1:0]      snd_byte;

  // result register
  logic                                out_valid;
  logic [uart_rb_pkg::OUT_TDATA_W-1:0] out_data;

  assign adv           = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_opcode <= s_axis_tdata[2:0];
      in_data   <= s_axis_tdata[10:3];
      in_status <= s_axis_tdata[13:11];
    end
  end

  // event decode; ring control only acts when the event moves on
  always_comb begin
    tx_ctl      = '0;
    rx_ctl      = '0;
    irq_en_next = irq_en;
    ovf_next    = ovf;
    err_next    = err;
    rd_byte     = '0;
    snd_valid   = 1'b0;
    snd_byte    = '0;
    if (adv) begin
      case (uart_rb_pkg::opcode_t'(in_opcode))
        uart_rb_pkg::OP_HOST_WRITE: begin
          if (tx_stat.full) begin
            ovf_next = 1'b1;
          end else begin
            ovf_next    = 1'b0;
            tx_ctl.push = 1'b1;
            irq_en_next = 1'b1;
          end
        end
        uart_rb_pkg::OP_HOST_READ: begin
          if (!rx_stat.empty) begin
            rd_byte    = rx_head;
            rx_ctl.pop = 1'b1;
          end
        end
        uart_rb_pkg::OP_LINE_RX: begin
          err_next    = in_status;
          rx_ctl.push = 1'b1;  // dropped quietly by the ring when full
        end
        uart_rb_pkg::OP_TX_READY: begin
          if (!tx_stat.empty) begin
            snd_valid  = 1'b1;
            snd_byte   = tx_head;
            tx_ctl.pop = 1'b1;
          end else begin
            irq_en_next = 1'b0;
          end
        end
        uart_rb_pkg::OP_TX_FLUSH: tx_ctl.flush = 1'b1;
        uart_rb_pkg::OP_RX_FLUSH: rx_ctl.flush = 1'b1;
        default: ;  // unused codes: status only
      endcase
    end
  end

  uart_rb_ring #(.MAX_SLOTS(MAX_SLOTS)) u_tx_ring (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we && (cfg_index == uart_rb_pkg::REG_TX_SIZE)),
    .cfg_data   (cfg_data),
    .ctl        (tx_ctl),
    .wdata      (in_data),
    .stat       (tx_stat),
    .head       (tx_head),
    .count_next (tx_cnt)
  );

  uart_rb_ring #(.MAX_SLOTS(MAX_SLOTS)) u_rx_ring (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we && (cfg_index == uart_rb_pkg::REG_RX_SIZE)),
    .cfg_data   (cfg_data),
    .ctl        (rx_ctl),
    .wdata      (in_data),
    .stat       (rx_stat),
    .head       (rx_head),
    .count_next (rx_cnt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_en    <= 1'b0;
      ovf       <= 1'b0;
      err       <= '0;
      out_valid <= 1'b0;
    end else begin
      irq_en <= irq_en_next;
      ovf    <= ovf_next;
      err    <= err_next;
      if (adv) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= {2'b00, tx_cnt, rx_cnt, err_next, ovf_next, irq_en_next,
                   snd_byte, snd_valid, rd_byte};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

// ===== design/uart_rb_checker.sv =====
// ----------------------------------------------------------------------------
// uart_rb_checker
// Port-level checks on the ring buffer block, bound to the top level.
// ----------------------------------------------------------------------------
module uart_rb_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  s_axis_tvalid,
  input logic                                  s_axis_tready,
  input logic [uart_rb_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input logic                                  m_axis_tvalid,
  input logic                                  m_axis_tready
);

  // nothing comes out in the cycle after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid straight after reset");

  // stalled result is held
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // no byte reported unless one is sent
  a_send_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[16:9] == 8'd0)
    else $error("send_byte set without send_valid");

  // a send always leaves the interrupt enable set
  a_send_irq: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[17])
    else $error("byte sent with interrupt enable clear");

  // an input request accepted while the output is free always yields a result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid)
    else $error("result missing after accepted request");

endmodule

bind uart_tx_rx_ring_buffers_top uart_rb_checker u_uart_rb_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
